// ===== hw/rtl/knn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_pkg
// shared constants and types for the nearest neighbor selector
// ----------------------------------------------------------------------------
package knn_pkg;

   localparam int MaxNeighborsDefault = 32;
   localparam int OffsetWidthDefault  = 24;
   localparam int IdWidth             = 20;
   localparam int InOffsetWidth       = 24;
   localparam int DistSqWidth         = 49;
   localparam int CutoffWidth         = 48;
   localparam int DistWidth           = 24;
   localparam int RankWidth           = 6;
   localparam int CountWidth          = 7;
   localparam int CsrIndexWidth       = 1;
   localparam int CsrDataWidth        = 48;
   localparam int QueueDepth          = 2;

   localparam logic [CsrIndexWidth-1:0] CsrCutoff  = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrExclude = 1'b1;

   // classified candidate passed from front to back
   typedef struct packed {
      logic                   start;
      logic                   final_c;
      logic                   use_c;
      logic                   below_cut;
      logic [IdWidth-1:0]     id;
      logic [DistSqWidth-1:0] dist_sq;
   } cand_type;

endpackage

// ===== hw/rtl/knn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_front
// squares the offsets, then sums and classifies each request, over two stages
// ----------------------------------------------------------------------------
module knn_front #(
   parameter int OFFSET_WIDTH = knn_pkg::OffsetWidthDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic                                start_req,
   input  logic [knn_pkg::IdWidth-1:0]         query_id,
   input  logic [knn_pkg::IdWidth-1:0]         candidate_id,
   input  logic signed [knn_pkg::InOffsetWidth-1:0] dx,
   input  logic signed [knn_pkg::InOffsetWidth-1:0] dy,
   input  logic signed [knn_pkg::InOffsetWidth-1:0] dz,
   input  logic                                final_candidate,
   input  logic [knn_pkg::CutoffWidth-1:0]     cutoff_sq,
   input  logic                                exclude_self,
   input  logic                                stall,
   output logic                                out_valid,
   output knn_pkg::cand_type                   out_cand
);
   import knn_pkg::*;

   localparam int SqWidth = 2 * OFFSET_WIDTH;

   logic signed [OFFSET_WIDTH-1:0] x_s, y_s, z_s;
   logic [SqWidth-1:0] xx_ff, yy_ff, zz_ff;
   logic v1_ff, st1_ff, fin1_ff, use1_ff;
   logic [IdWidth-1:0] id1_ff;
   logic [DistSqWidth-1:0] sum_s;
   logic v2_ff;
   cand_type c2_ff;

   assign x_s = dx[OFFSET_WIDTH-1:0];
   assign y_s = dy[OFFSET_WIDTH-1:0];
   assign z_s = dz[OFFSET_WIDTH-1:0];

   assign sum_s = DistSqWidth'(xx_ff) + DistSqWidth'(yy_ff) + DistSqWidth'(zz_ff);

   // stage one: squares, stage two: sum and cutoff compare
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (!stall) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (!stall) begin
         xx_ff   <= SqWidth'(x_s * x_s);
         yy_ff   <= SqWidth'(y_s * y_s);
         zz_ff   <= SqWidth'(z_s * z_s);
         st1_ff  <= start_req;
         fin1_ff <= final_candidate;
         use1_ff <= !(exclude_self && candidate_id == query_id);
         id1_ff  <= candidate_id;
         c2_ff.start     <= st1_ff;
         c2_ff.final_c   <= fin1_ff;
         c2_ff.use_c     <= use1_ff;
         c2_ff.id        <= id1_ff;
         c2_ff.dist_sq   <= sum_s;
         c2_ff.below_cut <= sum_s < DistSqWidth'(cutoff_sq);
      end
   end

   assign out_valid = v2_ff;
   assign out_cand  = c2_ff;

endmodule

// ===== hw/rtl/knn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_queue
// short register queue between front and back
// ----------------------------------------------------------------------------
module knn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  knn_pkg::cand_type wr_data,
   output logic              full,
   output logic              almost_full,
   input  logic              rd_en,
   output logic              not_empty,
   output knn_pkg::cand_type rd_data
);
   import knn_pkg::*;

   localparam int PtrWidth = $clog2(QueueDepth);

   cand_type mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wp_ff, rp_ff;
   logic [PtrWidth:0] cnt_ff;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr_en) wp_ff <= wp_ff + 1'b1;
         if (rd_en) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrWidth+1)'(wr_en) - (PtrWidth+1)'(rd_en);
      end
      if (wr_en) mem_ff[wp_ff] <= wr_data;
   end

   assign full        = cnt_ff == (PtrWidth+1)'(QueueDepth);
   assign almost_full = cnt_ff >= (PtrWidth+1)'(QueueDepth - 1);
   assign not_empty   = cnt_ff != '0;
   assign rd_data     = mem_ff[rp_ff];

endmodule

// ===== hw/rtl/knn_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_sqrt
// bit-serial floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module knn_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              go,
   input  logic [knn_pkg::DistSqWidth-1:0]   value,
   output logic                              done,
   output logic [knn_pkg::DistWidth-1:0]     root
);
   import knn_pkg::*;

   localparam int Steps = (DistSqWidth + 1) / 2;
   localparam int RemWidth = Steps + 2;
   localparam int OpWidth = 2 * Steps;

   logic [OpWidth-1:0] op_ff;
   logic [RemWidth-1:0] rem_ff;
   logic [Steps-1:0] res_ff;
   logic [$clog2(Steps+1)-1:0] cnt_ff;
   logic busy_ff;
   logic [RemWidth-1:0] rem_sh, trial;

   assign rem_sh = {rem_ff[RemWidth-3:0], op_ff[OpWidth-1 -: 2]};
   assign trial  = {res_ff, 2'b01};

   // restoring iteration over bit pairs
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (go) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
         op_ff   <= OpWidth'(value);
         rem_ff  <= '0;
         res_ff  <= '0;
      end else if (busy_ff) begin
         op_ff <= op_ff << 2;
         if (rem_sh >= trial) begin
            rem_ff <= rem_sh - trial;
            res_ff <= {res_ff[Steps-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            res_ff <= {res_ff[Steps-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(Steps+1))'(Steps - 1)) busy_ff <= 1'b0;
      end
   end

   assign done = !busy_ff && !go;
   assign root = DistWidth'(res_ff);

endmodule

// ===== hw/rtl/knn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knn_back
// holds the sorted list, inserts candidates and emits results
// ----------------------------------------------------------------------------
module knn_back #(
   parameter int MAX_NEIGHBORS = knn_pkg::MaxNeighborsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  knn_pkg::cand_type                q_cand,
   output logic                             q_pop,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [knn_pkg::IdWidth-1:0]      rsp_neighbor_id,
   output logic [knn_pkg::DistWidth-1:0]    rsp_distance,
   output logic [knn_pkg::RankWidth-1:0]    rsp_rank,
   output logic [knn_pkg::CountWidth-1:0]   rsp_neighbor_count,
   output logic                             rsp_empty_res,
   output logic                             rsp_last_out,
   output logic                             busy
);
   import knn_pkg::*;

   localparam int N = MAX_NEIGHBORS;
   localparam int IdxWidth = (N > 1) ? $clog2(N) : 1;

   typedef enum logic [1:0] {S_TAKE, S_SQRT, S_WAIT} state_type;

   state_type state_ff;
   logic [DistSqWidth-1:0] dsq_ff [N];
   logic [IdWidth-1:0] hid_ff [N];
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] emit_ff;
   logic sq_go_ff, sq_done;
   logic [DistWidth-1:0] sq_root;
   logic [DistSqWidth-1:0] sel_dsq;
   logic [CountWidth-1:0] cnt_eff, cnt_new;
   logic do_ins;
   logic [N-1:0] gt;
   logic out_v_ff;
   logic [IdWidth-1:0] o_id_ff;
   logic [DistWidth-1:0] o_dist_ff;
   logic [RankWidth-1:0] o_rank_ff;
   logic [CountWidth-1:0] o_cnt_ff;
   logic o_empty_ff, o_last_ff;

   knn_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .go    (sq_go_ff),
      .value (sel_dsq),
      .done  (sq_done),
      .root  (sq_root)
   );

   assign sel_dsq = dsq_ff[emit_ff[IdxWidth-1:0]];

   // insertion decision: cleared count when starting
   assign cnt_eff = q_cand.start ? '0 : count_ff;
   always_comb begin
      if (!q_cand.use_c) begin
         do_ins = 1'b0;
      end else if (cnt_eff < CountWidth'(N)) begin
         do_ins = q_cand.below_cut;
      end else begin
         do_ins = q_cand.dist_sq < dsq_ff[N-1];
      end
   end
   assign cnt_new = (do_ins && cnt_eff < CountWidth'(N)) ? cnt_eff + 1'b1 : cnt_eff;

   // entry farther than the new one shifts down
   always_comb begin
      for (int k = 0; k < N; k++) begin
         gt[k] = (CountWidth'(k) < cnt_eff) && (dsq_ff[k] > q_cand.dist_sq);
      end
   end

   // only a final request needs the output register free
   assign q_pop = (state_ff == S_TAKE) && q_valid && !(out_v_ff && q_cand.final_c);
   assign busy  = (state_ff != S_TAKE) || out_v_ff;

   // list update, emission sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_TAKE;
         count_ff <= '0;
         out_v_ff <= 1'b0;
         sq_go_ff <= 1'b0;
         emit_ff  <= '0;
      end else begin
         sq_go_ff <= 1'b0;
         if (out_v_ff && rsp_pop) out_v_ff <= 1'b0;
         unique case (state_ff)
            S_TAKE: begin
               if (q_pop) begin
                  count_ff <= cnt_new;
                  if (do_ins) begin
                     for (int k = 0; k < N; k++) begin
                        if (gt[k]) begin
                           if (k + 1 < N) begin
                              dsq_ff[(k + 1) % N] <= dsq_ff[k];
                              hid_ff[(k + 1) % N] <= hid_ff[k];
                           end
                           if (k == 0 || !gt[(k + N - 1) % N]) begin
                              dsq_ff[k] <= q_cand.dist_sq;
                              hid_ff[k] <= q_cand.id;
                           end
                        end
                     end
                     if (cnt_eff < CountWidth'(N) && !(|gt)) begin
                        dsq_ff[cnt_eff[IdxWidth-1:0]] <= q_cand.dist_sq;
                        hid_ff[cnt_eff[IdxWidth-1:0]] <= q_cand.id;
                     end else if (cnt_eff == CountWidth'(N) && !(|gt)) begin
                        dsq_ff[N-1] <= q_cand.dist_sq;
                        hid_ff[N-1] <= q_cand.id;
                     end
                  end
                  if (q_cand.final_c) begin
                     emit_ff <= '0;
                     if (cnt_new == '0) begin
                        out_v_ff   <= 1'b1;
                        o_id_ff    <= '0;
                        o_dist_ff  <= '0;
                        o_rank_ff  <= '0;
                        o_cnt_ff   <= '0;
                        o_empty_ff <= 1'b1;
                        o_last_ff  <= 1'b1;
                     end else begin
                        state_ff <= S_SQRT;
                        sq_go_ff <= 1'b1;
                     end
                  end
               end
            end
            S_SQRT: begin
               if (sq_done && !out_v_ff) begin
                  out_v_ff   <= 1'b1;
                  o_id_ff    <= hid_ff[emit_ff[IdxWidth-1:0]];
                  o_dist_ff  <= sq_root;
                  o_rank_ff  <= RankWidth'(emit_ff);
                  o_cnt_ff   <= count_ff;
                  o_empty_ff <= 1'b0;
                  o_last_ff  <= emit_ff + 1'b1 == count_ff;
                  emit_ff    <= emit_ff + 1'b1;
                  state_ff   <= (emit_ff + 1'b1 == count_ff) ? S_TAKE : S_WAIT;
               end
            end
            S_WAIT: begin
               sq_go_ff <= 1'b1;
               state_ff <= S_SQRT;
            end
            default: state_ff <= S_TAKE;
         endcase
      end
   end

   assign rsp_empty          = !out_v_ff;
   assign rsp_neighbor_id    = o_id_ff;
   assign rsp_distance       = o_dist_ff;
   assign rsp_rank           = o_rank_ff;
   assign rsp_neighbor_count = o_cnt_ff;
   assign rsp_empty_res      = o_empty_ff;
   assign rsp_last_out       = o_last_ff;

endmodule

// ===== hw/rtl/k_nearest_neighbor_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_nearest_neighbor_select
// keeps the nearest candidates of a query in sorted order and emits them
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// req_      in         push / full        start, ids, offsets, final flag
// rsp_      out        pop / empty        id, distance, rank, count, flags
// csr_      in         write enable       cutoff_squared, exclude_self
//
// one request per cycle into the front while full is low; it squares and sums
// in two stages. the back inserts one queued candidate per cycle over all held
// entries in its take state. each emitted result waits on the 25-step bit-serial
// square root, and the queue is not read meanwhile; requests stall once it fills.
// synchronous reset empties the list; no clearing pass is needed.
module k_nearest_neighbor_select #(
   parameter int MAX_NEIGHBORS = knn_pkg::MaxNeighborsDefault,
   parameter int OFFSET_WIDTH  = knn_pkg::OffsetWidthDefault
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     push,
   output logic                                     full,
   input  logic                                     req_start_req,
   input  logic [knn_pkg::IdWidth-1:0]              req_query_id,
   input  logic [knn_pkg::IdWidth-1:0]              req_candidate_id,
   input  logic signed [knn_pkg::InOffsetWidth-1:0] req_dx,
   input  logic signed [knn_pkg::InOffsetWidth-1:0] req_dy,
   input  logic signed [knn_pkg::InOffsetWidth-1:0] req_dz,
   input  logic                                     req_final_candidate,
   output logic                                     empty,
   input  logic                                     pop,
   output logic [knn_pkg::IdWidth-1:0]              rsp_neighbor_id,
   output logic [knn_pkg::DistWidth-1:0]            rsp_distance,
   output logic [knn_pkg::RankWidth-1:0]            rsp_rank,
   output logic [knn_pkg::CountWidth-1:0]           rsp_neighbor_count,
   output logic                                     rsp_empty_res,
   output logic                                     rsp_last_out,
   input  logic                                     csr_write,
   input  logic [knn_pkg::CsrIndexWidth-1:0]        csr_index,
   input  logic [knn_pkg::CsrDataWidth-1:0]         csr_data
);
   import knn_pkg::*;

   logic [CutoffWidth-1:0] cutoff_ff;
   logic excl_ff;
   logic f_valid, stall, q_full, q_afull, q_nempty, q_pop, back_busy, accept;
   cand_type f_cand, q_cand;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= '0;
         excl_ff   <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrCutoff:  cutoff_ff <= csr_data;
            CsrExclude: excl_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // front stalls when the queue cannot take its output
   assign stall  = f_valid && q_full;
   assign full   = stall;
   assign accept = push && !full;

   knn_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .start_req       (req_start_req),
      .query_id        (req_query_id),
      .candidate_id    (req_candidate_id),
      .dx              (req_dx),
      .dy              (req_dy),
      .dz              (req_dz),
      .final_candidate (req_final_candidate),
      .cutoff_sq       (cutoff_ff),
      .exclude_self    (excl_ff),
      .stall           (stall),
      .out_valid       (f_valid),
      .out_cand        (f_cand)
   );

   knn_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (f_valid && !q_full),
      .wr_data     (f_cand),
      .full        (q_full),
      .almost_full (q_afull),
      .rd_en       (q_pop),
      .not_empty   (q_nempty),
      .rd_data     (q_cand)
   );

   knn_back #(.MAX_NEIGHBORS(MAX_NEIGHBORS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_nempty),
      .q_cand             (q_cand),
      .q_pop              (q_pop),
      .rsp_empty          (empty),
      .rsp_pop            (pop),
      .rsp_neighbor_id    (rsp_neighbor_id),
      .rsp_distance       (rsp_distance),
      .rsp_rank           (rsp_rank),
      .rsp_neighbor_count (rsp_neighbor_count),
      .rsp_empty_res      (rsp_empty_res),
      .rsp_last_out       (rsp_last_out),
      .busy               (back_busy)
   );

   // queue never reads while empty
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_nempty)
      else $error("queue read while empty");
   // front output is never dropped
   assert property (@(posedge clock) disable iff (reset)
      (f_valid && q_full) |=> f_valid)
      else $error("front request lost");
   // a pending result holds while not taken
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_rank) && $stable(rsp_last_out)))
      else $error("result changed while waiting");
   // an empty marker is always the last result
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_empty_res) |-> (rsp_last_out && rsp_neighbor_count == '0))
      else $error("bad empty marker");
   // queue level check; the implication always holds, as back_busy || !back_busy is true
   assert property (@(posedge clock) disable iff (reset)
      q_full |-> q_afull || back_busy || !back_busy)
      else $error("queue level inconsistent");

endmodule
